// File: rtl/bwsid_pkg.sv
// Shared constants, widths and helper functions of the Bayer window-sum downsampler.
package bwsid_pkg;

  localparam int MAX_WIDTH = 2048;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int BX_W      = COL_W - 1;
  localparam int HALF_DEPTH = MAX_WIDTH / 2;

  localparam int FW_W      = 12;
  localparam int FH_W      = 16;
  localparam int SAMPLE_W  = 16;
  localparam int PIXEL_W   = 8;
  localparam int QUART_W   = 6;
  localparam int HALF_W    = 7;
  localparam int SUM_W     = SAMPLE_W + 2;

  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;

  localparam logic [PADDR_W-1:0] REG_FRAME_WIDTH  = 3'd0;
  localparam logic [PADDR_W-1:0] REG_FRAME_HEIGHT = 3'd4;

  localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = 12'd640;
  localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = 16'd480;

  localparam logic [FW_W-1:0] WIDTH_CAP = FW_W'(((MAX_WIDTH / 2) * 2));

  function automatic logic [QUART_W-1:0] inv_quarter(input logic [SUM_W-1:0] sum);
    logic [7:0] inv;
    inv = 8'd255 - sum[SUM_W-1:10];
    return inv[7:2];
  endfunction

  function automatic logic [FW_W-1:0] eff_width(input logic [FW_W-1:0] fw);
    logic [FW_W-1:0] w;
    w = {fw[FW_W-1:1], 1'b0};
    if (w < FW_W'(2)) w = FW_W'(2);
    if (w > WIDTH_CAP) w = WIDTH_CAP;
    return w;
  endfunction

  function automatic logic [FH_W-1:0] eff_height(input logic [FH_W-1:0] fh);
    logic [FH_W-1:0] h;
    h = {fh[FH_W-1:1], 1'b0};
    if (h < FH_W'(2)) h = FH_W'(2);
    return h;
  endfunction

endpackage

// File: rtl/bwsid_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module bwsid_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/bayer_window_sum_invert_downsample_core.sv
// Bayer 2x2 window sum, inversion and 2x2 average downsample, top level.
//
//  channel | ports                                  | direction
//  --------+----------------------------------------+----------
//  input   | in_valid, in_stall, in_raw_sample      | in
//  output  | out_valid, out_stall, out_pixel,       | out
//          | out_end_of_frame                       |
//  config  | psel, penable, pwrite, paddr, pwdata,  | in/out
//          | prdata, pready                         |
//
// One raw sample per cycle is taken while the input is not stalled; a beat
// passes the input register and then the result register. The line buffer
// reads are issued at acceptance, their registered data meets the sample in the
// input register. Reset clears position and side state; the line buffers need
// no clearing. A stall on the output holds the input register and stalls the
// input only while both registers are full.
module bayer_window_sum_invert_downsample_core
  import bwsid_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [SAMPLE_W-1:0] in_raw_sample,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [PIXEL_W-1:0]  out_pixel,
  output logic                out_end_of_frame,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [PDATA_W-1:0]  pwdata,
  output logic [PDATA_W-1:0]  prdata,
  output logic                pready
);

  logic [FW_W-1:0] frame_width_r, frame_width_nxt;
  logic [FH_W-1:0] frame_height_r, frame_height_nxt;

  logic [COL_W-1:0] col_cnt_r, col_cnt_nxt;
  logic [FH_W-1:0]  row_cnt_r, row_cnt_nxt;

  logic                a_vld_r, a_vld_nxt;
  logic [SAMPLE_W-1:0] a_sample_r;
  logic [COL_W-1:0]    a_col_r;
  logic [BX_W-1:0]     a_bx_r;
  logic                a_act_r, a_odd_c_r, a_last_c_r, a_last_r_r, a_odd_r_r;
  logic                a_byp_r;
  logic [HALF_W-1:0]   a_byp_d_r;

  logic [SAMPLE_W-1:0] left0_r, left0_nxt, left1_r, left1_nxt;
  logic [QUART_W-1:0]  pend_q_r, pend_q_nxt;

  logic               out_vld_r, out_vld_nxt;
  logic [PIXEL_W-1:0] out_pix_r;
  logic               out_eof_r;

  logic [FW_W-1:0]     w_eff;
  logic [FH_W-1:0]     h_eff;
  logic [COL_W-1:0]    c_cur;
  logic [FH_W-1:0]     r_cur;
  logic                last_c, last_r;
  logic [BX_W-1:0]     bx_cur;
  logic                in_acc, adv, cfg_wr;

  logic [SAMPLE_W-1:0] up_data;
  logic [HALF_W-1:0]   half_rd;
  logic [HALF_W-1:0]   half_up;
  logic                half_we;
  logic [HALF_W-1:0]   half_wd;
  logic [QUART_W-1:0]  qa, qb, ql, qm;
  logic                emit;
  logic [PIXEL_W-1:0]  pix;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    frame_width_nxt  = frame_width_r;
    frame_height_nxt = frame_height_r;
    if (cfg_wr) begin
      case (paddr)
        REG_FRAME_WIDTH:  frame_width_nxt  = pwdata[FW_W-1:0];
        REG_FRAME_HEIGHT: frame_height_nxt = pwdata[FH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr)
      REG_FRAME_WIDTH:  prdata = PDATA_W'(frame_width_r);
      REG_FRAME_HEIGHT: prdata = PDATA_W'(frame_height_r);
      default:          prdata = '0;
    endcase
  end

  // position of the incoming beat
  assign w_eff  = eff_width(frame_width_r);
  assign h_eff  = eff_height(frame_height_r);
  assign c_cur  = ({1'b0, col_cnt_r} >= w_eff) ? COL_W'(w_eff - FW_W'(1)) : col_cnt_r;
  assign r_cur  = (row_cnt_r >= h_eff) ? (h_eff - FH_W'(1)) : row_cnt_r;
  assign last_c = ({1'b0, c_cur} == (w_eff - FW_W'(1)));
  assign last_r = (r_cur == (h_eff - FH_W'(1)));
  assign bx_cur = c_cur[0] ? c_cur[COL_W-1:1] : (c_cur[COL_W-1:1] - BX_W'(1));

  assign adv      = a_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = a_vld_r && out_vld_r && out_stall;
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    col_cnt_nxt = col_cnt_r;
    row_cnt_nxt = row_cnt_r;
    if (in_acc) begin
      if (last_c) begin
        col_cnt_nxt = '0;
        row_cnt_nxt = last_r ? '0 : (r_cur + FH_W'(1));
      end else begin
        col_cnt_nxt = c_cur + COL_W'(1);
        row_cnt_nxt = r_cur;
      end
    end
  end

  always_comb begin
    a_vld_nxt = a_vld_r;
    if (in_acc) begin
      a_vld_nxt = 1'b1;
    end else if (adv) begin
      a_vld_nxt = 1'b0;
    end
  end

  // line buffers
  bwsid_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_WIDTH)) u_raw_row (
    .clk   (clk),
    .we    (adv),
    .waddr (a_col_r),
    .wdata (a_sample_r),
    .re    (in_acc),
    .raddr (c_cur),
    .rdata (up_data)
  );

  bwsid_ram #(.WIDTH(HALF_W), .DEPTH(HALF_DEPTH)) u_half_row (
    .clk   (clk),
    .we    (half_we),
    .waddr (a_bx_r),
    .wdata (half_wd),
    .re    (in_acc),
    .raddr (bx_cur),
    .rdata (half_rd)
  );

  // take the entry written on the accepting edge from the bypass
  assign half_up = a_byp_r ? a_byp_d_r : half_rd;

  // window sums and block averaging
  assign qa = inv_quarter(SUM_W'(a_sample_r) + SUM_W'(up_data) + SUM_W'(left0_r)
                          + SUM_W'(left1_r));
  assign qb = inv_quarter(SUM_W'(a_sample_r) + SUM_W'(up_data));
  assign ql = inv_quarter(SUM_W'(a_sample_r) + SUM_W'(left0_r));
  assign qm = inv_quarter(SUM_W'(a_sample_r));

  always_comb begin
    emit       = 1'b0;
    pix        = '0;
    half_we    = 1'b0;
    half_wd    = '0;
    pend_q_nxt = pend_q_r;
    left0_nxt  = left0_r;
    left1_nxt  = left1_r;
    if (adv) begin
      left0_nxt = a_sample_r;
      left1_nxt = up_data;
      if (a_act_r) begin
        if (a_last_r_r) begin
          if (a_last_c_r) begin
            emit = 1'b1;
            pix  = PIXEL_W'(qa) + PIXEL_W'(qb) + PIXEL_W'(ql) + PIXEL_W'(qm);
          end else if (a_odd_c_r) begin
            half_we    = 1'b1;
            half_wd    = HALF_W'(qa);
            pend_q_nxt = ql;
          end else begin
            emit = 1'b1;
            pix  = PIXEL_W'(half_up) + PIXEL_W'(qa) + PIXEL_W'(pend_q_r) + PIXEL_W'(ql);
          end
        end else if (a_odd_r_r) begin
          if (a_last_c_r) begin
            half_we = 1'b1;
            half_wd = HALF_W'(qa) + HALF_W'(qb);
          end else if (a_odd_c_r) begin
            pend_q_nxt = qa;
          end else begin
            half_we = 1'b1;
            half_wd = HALF_W'(pend_q_r) + HALF_W'(qa);
          end
        end else begin
          if (a_last_c_r) begin
            emit = 1'b1;
            pix  = PIXEL_W'(half_up) + PIXEL_W'(qa) + PIXEL_W'(qb);
          end else if (a_odd_c_r) begin
            pend_q_nxt = qa;
          end else begin
            emit = 1'b1;
            pix  = PIXEL_W'(half_up) + PIXEL_W'(pend_q_r) + PIXEL_W'(qa);
          end
        end
      end
    end
  end

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (adv) begin
      out_vld_nxt = emit;
    end else if (!out_stall) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= FRAME_WIDTH_RST;
      frame_height_r <= FRAME_HEIGHT_RST;
      col_cnt_r      <= '0;
      row_cnt_r      <= '0;
      a_vld_r        <= 1'b0;
      left0_r        <= '0;
      left1_r        <= '0;
      pend_q_r       <= '0;
      out_vld_r      <= 1'b0;
    end else begin
      frame_width_r  <= frame_width_nxt;
      frame_height_r <= frame_height_nxt;
      col_cnt_r      <= col_cnt_nxt;
      row_cnt_r      <= row_cnt_nxt;
      a_vld_r        <= a_vld_nxt;
      left0_r        <= left0_nxt;
      left1_r        <= left1_nxt;
      pend_q_r       <= pend_q_nxt;
      out_vld_r      <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      a_sample_r <= in_raw_sample;
      a_col_r    <= c_cur;
      a_bx_r     <= bx_cur;
      a_act_r    <= (c_cur != '0) && (r_cur != '0);
      a_odd_c_r  <= c_cur[0];
      a_odd_r_r  <= r_cur[0];
      a_last_c_r <= last_c;
      a_last_r_r <= last_r;
      a_byp_r    <= half_we && (a_bx_r == bx_cur);
      a_byp_d_r  <= half_wd;
    end
    if (adv && emit) begin
      out_pix_r <= pix;
      out_eof_r <= a_last_r_r && a_last_c_r;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_pixel        = out_pix_r;
  assign out_end_of_frame = out_eof_r;

  a_frame_end_emits: assert property (@(posedge clk) disable iff (!rst_n)
    adv && a_act_r && a_last_c_r && a_last_r_r |=> out_valid && out_end_of_frame)
    else $error("frame end beat gave no end-of-frame result");

  a_wrap_after_frame: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && last_c && last_r |=> col_cnt_r == '0 && row_cnt_r == '0)
    else $error("position did not wrap after the last beat of a frame");

  a_no_result_inactive: assert property (@(posedge clk) disable iff (!rst_n)
    adv && !a_act_r |=> !out_valid)
    else $error("result from a beat of the first row or column");

  a_stall_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> a_vld_r && out_valid && out_stall)
    else $error("input stalled with a free register");

endmodule
